// File: hw/rtl/uirhe_pkg.sv
`timescale 1ns / 1ps
package uirhe_pkg;

	localparam int MAX_REGIONS_DEF = 16;
	localparam int RESULT_CAP      = 32;

	localparam int COUNT_W  = 5;
	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int COORD_W  = 13;
	localparam int SIZE_W   = 12;
	localparam int FLAGS_W  = 16;
	localparam int ACTION_W = 16;
	localparam int REL_W    = 14;

	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 64;

	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MOVE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_BUTTON = 2'd2;

	localparam int FLAG_IGNORE = 0;
	localparam int FLAG_SCROLL = 1;
	localparam int FLAG_ENTER  = 2;
	localparam int FLAG_LEAVE  = 3;
	localparam int FLAG_HOVER  = 4;

	localparam logic [FLAGS_W-1:0] CODE_ENTER = 16'h0004;
	localparam logic [FLAGS_W-1:0] CODE_LEAVE = 16'h0008;
	localparam logic [FLAGS_W-1:0] CODE_HOVER = 16'h0010;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic [FLAGS_W-1:0]        flags;
		logic [ACTION_W-1:0]       action;
	} region_entry_t;

	typedef struct packed {
		logic                    ignore;
		logic                    holds_old;
		logic                    holds_new;
		logic signed [REL_W-1:0] rel_x;
		logic signed [REL_W-1:0] rel_y;
	} hit_t;

	typedef struct packed {
		logic signed [REL_W-1:0] rel_y;
		logic signed [REL_W-1:0] rel_x;
		logic [FLAGS_W-1:0]      code;
		logic [ACTION_W-1:0]     action;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

endpackage

// File: hw/rtl/ui_region_hit_event_engine.sv
`timescale 1ns / 1ps
// Region hit-test event engine.
// cfg channel (cfg_valid/cfg_ready/cfg_data) sets the number of table entries in
// use; cfg_ready is always high. Write it only while no item is in progress.
// Input items arrive on s_tvalid/s_tready/s_tdata with the function code on
// s_tuser. A load item writes one table entry in the cycle it is accepted and
// gives no event. A move or button item walks the table from entry 0 through a
// registered table memory, one entry per cycle while the output does not stall.
//   button: one pass; it stops after the first matching entry with the scroll flag
//   move:   leave pass, then enter/hover pass; an entry that gives both enter
//           and hover is held in the stage until its hover event is given.
// s_tready is high only between items. Events leave on m_tvalid/m_tready/m_tdata
// with m_tlast on the last event of an item; an item without events gives none.
// Each event sits in a holding register until the next one is known, then in
// the output register, so a stalled receiver holds the walk but the next item
// is taken while the final event still waits. Reset clears the cursor, the
// entry count and all handshake state; table contents are undefined until
// loaded.
module ui_region_hit_event_engine #(
	parameter int MAX_REGIONS = uirhe_pkg::MAX_REGIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uirhe_pkg::COUNT_W-1:0]     cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// region_index, region_x, region_y, region_w, region_h, region_flags,
	// region_action, cursor_x, cursor_y, button_mask
	input  logic [uirhe_pkg::S_TDATA_W-1:0]   s_tdata,
	// func
	input  logic [uirhe_pkg::FUNC_W-1:0]      s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// event_action, event_code, rel_x, rel_y, zero pad
	output logic [uirhe_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import uirhe_pkg::*;

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int EW = $clog2(RESULT_CAP + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [1:0] PASS_LEAVE  = 2'd0;
	localparam logic [1:0] PASS_ENTER  = 2'd1;
	localparam logic [1:0] PASS_BUTTON = 2'd2;

	// input fields
	logic [INDEX_W-1:0]        in_index;
	logic signed [COORD_W-1:0] in_cursor_x, in_cursor_y;
	logic [FLAGS_W-1:0]        in_mask;
	region_entry_t             in_entry;

	assign in_index        = s_tdata[3:0];
	assign in_entry.x      = $signed(s_tdata[16:4]);
	assign in_entry.y      = $signed(s_tdata[29:17]);
	assign in_entry.w      = s_tdata[41:30];
	assign in_entry.h      = s_tdata[53:42];
	assign in_entry.flags  = s_tdata[69:54];
	assign in_entry.action = s_tdata[85:70];
	assign in_cursor_x     = $signed(s_tdata[98:86]);
	assign in_cursor_y     = $signed(s_tdata[111:99]);
	assign in_mask         = s_tdata[127:112];

	logic [1:0]                state_q, pass_q;
	logic [CW-1:0]             ptr_q, cnt_act;
	logic                      valid_s1, sub_s1, accept_q;
	logic [EW-1:0]             ev_cnt_q;
	logic [COUNT_W-1:0]        region_count_q;
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, new_x_q, new_y_q;
	logic [FLAGS_W-1:0]        mask_q;
	logic                      pend_valid_q, out_valid_q, out_last_q;
	event_t                    pend_q, out_q, new_ev;
	region_entry_t             entry_s1;
	region_entry_t             region_mem_q [MAX_REGIONS];

	logic   in_go, wr_en, rd_en, more, out_free, can_emit, room;
	logic   want, done_entry, acc_clr, brk_req;
	logic   step, consume, s1_free, brk, emit_go, push_mid, push_end;
	logic [FLAGS_W-1:0] ev_code;
	hit_t   hit;

	always_comb begin
		if (32'(region_count_q) > MAX_REGIONS) begin
			cnt_act = CW'(MAX_REGIONS);
		end else begin
			cnt_act = CW'(region_count_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_go     = s_tvalid && s_tready;
	assign wr_en     = in_go && (s_tuser == FUNC_LOAD) && (32'(in_index) < MAX_REGIONS);

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			region_mem_q[AW'(in_index)] <= in_entry;
		end
		if (rd_en) begin
			entry_s1 <= region_mem_q[ptr_q[AW-1:0]];
		end
	end

	uirhe_hit_eval u_hit_eval (
		.entry   (entry_s1),
		.old_x   (cur_x_q),
		.old_y   (cur_y_q),
		.new_x   (new_x_q),
		.new_y   (new_y_q),
		.rel_new (pass_q != PASS_BUTTON),
		.hit     (hit)
	);

	// per-entry event decision
	always_comb begin
		want       = 1'b0;
		ev_code    = mask_q;
		done_entry = 1'b1;
		acc_clr    = 1'b0;
		brk_req    = 1'b0;
		case (pass_q)
			PASS_LEAVE: begin
				want    = !hit.ignore && entry_s1.flags[FLAG_LEAVE] &&
				          hit.holds_old && !hit.holds_new;
				ev_code = CODE_LEAVE;
			end
			PASS_ENTER: begin
				if (!hit.ignore && hit.holds_new) begin
					if (entry_s1.flags[FLAG_ENTER] && !hit.holds_old && !sub_s1) begin
						want       = 1'b1;
						ev_code    = CODE_ENTER;
						done_entry = !(accept_q && entry_s1.flags[FLAG_HOVER]);
					end else if (accept_q && entry_s1.flags[FLAG_HOVER]) begin
						want    = 1'b1;
						ev_code = CODE_HOVER;
						acc_clr = entry_s1.flags[FLAG_SCROLL];
					end
				end
			end
			PASS_BUTTON: begin
				if (!hit.ignore && hit.holds_old && ((mask_q & entry_s1.flags) != '0)) begin
					want    = 1'b1;
					brk_req = entry_s1.flags[FLAG_SCROLL];
				end
			end
			default: begin
				want = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || m_tready;
	assign can_emit = !pend_valid_q || out_free;
	assign room     = ev_cnt_q < EW'(RESULT_CAP);
	assign more     = ptr_q < cnt_act;

	assign step     = (state_q == ST_WALK) && valid_s1 && !(want && room && !can_emit);
	assign consume  = step && done_entry;
	assign s1_free  = !valid_s1 || consume;
	assign brk      = step && brk_req;
	assign emit_go  = step && want && room;
	assign rd_en    = (state_q == ST_WALK) && s1_free && more && !brk;
	assign push_mid = emit_go && pend_valid_q;
	assign push_end = (state_q == ST_FLUSH) && pend_valid_q && out_free;

	assign new_ev.action = entry_s1.action;
	assign new_ev.code   = ev_code;
	assign new_ev.rel_x  = hit.rel_x;
	assign new_ev.rel_y  = hit.rel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pass_q         <= PASS_LEAVE;
			ptr_q          <= '0;
			valid_s1       <= 1'b0;
			sub_s1         <= 1'b0;
			accept_q       <= 1'b0;
			ev_cnt_q       <= '0;
			region_count_q <= '0;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
			out_last_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				region_count_q <= cfg_data;
			end
			if (out_valid_q && m_tready && !(push_mid || push_end)) begin
				out_valid_q <= 1'b0;
			end
			if (emit_go) begin
				ev_cnt_q     <= ev_cnt_q + EW'(1);
				pend_valid_q <= 1'b1;
			end
			if (push_mid) begin
				out_valid_q <= 1'b1;
				out_last_q  <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_go && (s_tuser == FUNC_MOVE || s_tuser == FUNC_BUTTON)) begin
						state_q  <= ST_WALK;
						pass_q   <= (s_tuser == FUNC_MOVE) ? PASS_LEAVE : PASS_BUTTON;
						ptr_q    <= '0;
						valid_s1 <= 1'b0;
						sub_s1   <= 1'b0;
						accept_q <= 1'b1;
						ev_cnt_q <= '0;
					end
				end
				ST_WALK: begin
					if (step) begin
						sub_s1 <= !done_entry;
						if (acc_clr) begin
							accept_q <= 1'b0;
						end
					end
					if (brk) begin
						valid_s1 <= 1'b0;
						state_q  <= ST_FLUSH;
					end else if (s1_free) begin
						valid_s1 <= more;
						if (more) begin
							ptr_q <= ptr_q + CW'(1);
						end else if (pass_q == PASS_LEAVE) begin
							pass_q <= PASS_ENTER;
							ptr_q  <= '0;
						end else begin
							state_q <= ST_FLUSH;
							if (pass_q == PASS_ENTER) begin
								cur_x_q <= new_x_q;
								cur_y_q <= new_y_q;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_go) begin
			new_x_q <= in_cursor_x;
			new_y_q <= in_cursor_y;
			mask_q  <= in_mask;
		end
		if (emit_go) begin
			pend_q <= new_ev;
		end
		if (push_mid || push_end) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_TDATA_W - EVENT_W){1'b0}}, out_q};

endmodule

// File: hw/rtl/uirhe_hit_eval.sv
`timescale 1ns / 1ps
module uirhe_hit_eval (
	input  uirhe_pkg::region_entry_t             entry,
	input  logic signed [uirhe_pkg::COORD_W-1:0] old_x,
	input  logic signed [uirhe_pkg::COORD_W-1:0] old_y,
	input  logic signed [uirhe_pkg::COORD_W-1:0] new_x,
	input  logic signed [uirhe_pkg::COORD_W-1:0] new_y,
	input  logic                                 rel_new,
	output uirhe_pkg::hit_t                      hit
);
	import uirhe_pkg::*;

	logic signed [REL_W-1:0] x_lo, y_lo, x_hi, y_hi;
	logic signed [REL_W-1:0] ox, oy, nx, ny, px, py;

	assign x_lo = $signed({entry.x[COORD_W-1], entry.x});
	assign y_lo = $signed({entry.y[COORD_W-1], entry.y});
	assign x_hi = x_lo + $signed({2'b00, entry.w});
	assign y_hi = y_lo + $signed({2'b00, entry.h});

	assign ox = $signed({old_x[COORD_W-1], old_x});
	assign oy = $signed({old_y[COORD_W-1], old_y});
	assign nx = $signed({new_x[COORD_W-1], new_x});
	assign ny = $signed({new_y[COORD_W-1], new_y});

	assign px = rel_new ? nx : ox;
	assign py = rel_new ? ny : oy;

	assign hit.ignore    = entry.flags[FLAG_IGNORE];
	assign hit.holds_old = (x_lo <= ox) && (ox < x_hi) && (y_lo <= oy) && (oy < y_hi);
	assign hit.holds_new = (x_lo <= nx) && (nx < x_hi) && (y_lo <= ny) && (ny < y_hi);
	assign hit.rel_x     = px - x_lo;
	assign hit.rel_y     = py - y_lo;

endmodule

// File: hw/rtl/uirhe_checker.sv
`timescale 1ns / 1ps
module uirhe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [uirhe_pkg::FUNC_W-1:0]    s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [uirhe_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);
	import uirhe_pkg::*;

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// load item leaves the block ready for the next item
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FUNC_LOAD |=> s_tready)
		else $error("not ready after load item");

	// move and button items start a walk
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FUNC_MOVE || s_tuser == FUNC_BUTTON)
		|=> !s_tready)
		else $error("ready during table walk");

	// events are only produced by a walk
	a_event_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("event appeared outside a walk");

endmodule

bind ui_region_hit_event_engine uirhe_checker u_uirhe_checker (.*);
